/* hdl/mhpq_pkg.sv */
// shared types and codes for the max-heap priority queue
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int VALUE_W  = 32;
    localparam int TOTAL_W  = 7;
    localparam int STATUS_W = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [STATUS_W-1:0]       t_status;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_EMPTY = 2'd2;

endpackage

/* hdl/max_heap_priority_queue_unit.sv */
// Binary max-heap priority queue of signed 32-bit values. Each request either inserts
// a value (tuser 0) or removes the maximum (tuser 1) and gives one result: the removed
// value (zero unless a remove succeeds), the entry count afterwards and a status
// (0 ok, 1 insert rejected full, 2 remove rejected empty). The heap sits in one memory
// of CAPACITY words with one write port and two registered read ports; the tree is
// walked one level at a time, with a read state and then a compare state per level.
// An insert sifts the value up until it reaches the root or a compare stops it; a
// remove loads the root and the last entry, then sifts that entry down until it
// reaches a leaf or a compare stops it. Removing the only entry and rejected requests
// skip the walk. A finished request waits in the done state while the output register
// is still full. The input is not ready while a request is being worked on; a finished
// result waits in the output register while the next request is taken.
`timescale 1ns / 1ps

module max_heap_priority_queue_unit
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] value
    input  logic                  s_axis_tuser,   // [0] operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] top_value, [38:32] entry_total
    output logic [STATUS_W-1:0]   m_axis_tuser    // [1:0] status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_RD   = 3'd1;
    localparam logic [2:0] S_UP_CMP  = 3'd2;
    localparam logic [2:0] S_RM_LOAD = 3'd3;
    localparam logic [2:0] S_DN_RD   = 3'd4;
    localparam logic [2:0] S_DN_CMP  = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pos, n_pos;
    t_value        r_val, n_val;
    t_value        r_top, n_top;
    t_status       r_status, n_status;

    logic          r_out_valid, n_out_valid;
    t_value        r_out_top, n_out_top;
    logic [TOTAL_W-1:0] r_out_total, n_out_total;
    t_status       r_out_status, n_out_status;

    t_value        r_mem [CAPACITY];
    t_value        r_rd0, r_rd1;
    logic [AW-1:0] ra0, ra1, wa;
    t_value        wd;
    logic          we;

    logic          in_acc;
    logic [CW:0]   child;
    logic [CW:0]   child_r;
    logic [CW-1:0] parent;
    logic          right_ok;
    logic          pick_right;
    t_value        big_val;
    logic [CW:0]   big_slot;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign child    = {r_pos, 1'b0};
    assign child_r  = child + (CW+1)'(1);
    assign parent   = r_pos >> 1;
    assign right_ok = child < {1'b0, r_count};
    assign pick_right = right_ok && (r_rd1 > r_rd0);
    assign big_val  = pick_right ? r_rd1 : r_rd0;
    assign big_slot = pick_right ? child_r : child;

    // memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd0 <= r_mem[ra0];
        r_rd1 <= r_mem[ra1];
    end

    // read addresses (slot k lives at address k-1)
    always_comb begin
        ra0 = '0;
        ra1 = AW'(r_count - ONE_C);
        unique case (r_state)
            S_UP_RD: begin
                ra0 = AW'(parent - ONE_C);
            end
            S_DN_RD: begin
                ra0 = AW'(child - (CW+1)'(1));
                ra1 = AW'(child);
            end
            default: begin
                ra0 = '0;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_val        = r_val;
        n_top        = r_top;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_top    = r_out_top;
        n_out_total  = r_out_total;
        n_out_status = r_out_status;
        we = 1'b0;
        wa = AW'(r_pos - ONE_C);
        wd = r_val;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_top    = '0;
                    n_status = STATUS_OK;
                    n_val    = t_value'(s_axis_tdata);
                    if (s_axis_tuser == OP_INSERT) begin
                        if (r_count >= CAP_C) begin
                            n_status = STATUS_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_count = r_count + ONE_C;
                            n_pos   = r_count + ONE_C;
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STATUS_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            // root and last entry are being read this cycle
                            n_count = r_count - ONE_C;
                            n_state = S_RM_LOAD;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == ONE_C) begin
                    we      = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                we = 1'b1;
                if (r_rd0 < r_val) begin
                    // parent moves down into the hole
                    wd      = r_rd0;
                    n_pos   = parent;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RM_LOAD: begin
                n_top = r_rd0;
                n_val = r_rd1;
                n_pos = ONE_C;
                if (r_count == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN_RD;
                end
            end
            S_DN_RD: begin
                if (child > {1'b0, r_count}) begin
                    we      = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                we = 1'b1;
                if (big_val > r_val) begin
                    // larger child moves up into the hole
                    wd      = big_val;
                    n_pos   = CW'(big_slot);
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_top    = r_top;
                    n_out_total  = TOTAL_W'({{TOTAL_W{1'b0}}, r_count});
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_top        <= n_top;
        r_status     <= n_status;
        r_out_top    <= n_out_top;
        r_out_total  <= n_out_total;
        r_out_status <= n_out_status;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-VALUE_W-TOTAL_W){1'b0}}, r_out_total, r_out_top};
    assign m_axis_tuser  = r_out_status;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == STATUS_FULL) |-> (r_count == CAP_C))
        else $error("full reject with room left");

    a_empty_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == STATUS_EMPTY) |-> (r_count == '0))
        else $error("empty reject with entries held");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != STATUS_OK) |-> (r_out_top == '0))
        else $error("rejected request carries a value");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("request taken while busy");
`endif

endmodule

/* tb/mhpq_result_checker.sv */
// watches both channels of the heap queue, predicts each result and compares
`timescale 1ns / 1ps

module mhpq_result_checker
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    input  logic                  i_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [31:0] value
    input  logic                  i_s_axis_tuser,   // [0] operation
    input  logic                  i_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic [OUT_DATA_W-1:0] i_m_axis_tdata,   // [31:0] top_value, [38:32] entry_total
    input  logic [STATUS_W-1:0]   i_m_axis_tuser,   // [1:0] status
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        t_value               top;
        logic [TOTAL_W-1:0]   total;
        t_status              status;
    } t_outcome;

    // slot 1 is the root, slot k has children 2k and 2k+1
    t_value      heap_mem [1:CAPACITY];
    int unsigned heap_count;
    t_outcome    outcome_q [$];
    int          fail_total;

    function automatic t_outcome apply_request(input logic op, input t_value val);
        t_outcome    res;
        int unsigned pos;
        int unsigned child;
        t_value      tmp;
        logic        moving;
        res = '0;
        res.status = STATUS_OK;
        if (op == OP_INSERT) begin
            if (heap_count >= CAPACITY) begin
                res.status = STATUS_FULL;
            end else begin
                heap_count++;
                heap_mem[heap_count] = val;
                pos = heap_count;
                moving = 1'b1;
                while (moving && pos > 1) begin
                    if (heap_mem[pos / 2] < heap_mem[pos]) begin
                        tmp = heap_mem[pos / 2];
                        heap_mem[pos / 2] = heap_mem[pos];
                        heap_mem[pos] = tmp;
                        pos = pos / 2;
                    end else begin
                        moving = 1'b0;
                    end
                end
            end
        end else if (heap_count == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.top = heap_mem[1];
            heap_mem[1] = heap_mem[heap_count];
            heap_count--;
            pos = 1;
            child = 2;
            moving = 1'b1;
            while (moving && child <= heap_count) begin
                // equal children: the left one wins
                if (child + 1 <= heap_count && heap_mem[child + 1] > heap_mem[child]) begin
                    child++;
                end
                if (heap_mem[child] > heap_mem[pos]) begin
                    tmp = heap_mem[child];
                    heap_mem[child] = heap_mem[pos];
                    heap_mem[pos] = tmp;
                    pos = child;
                    child = 2 * pos;
                end else begin
                    moving = 1'b0;
                end
            end
        end
        res.total = TOTAL_W'(heap_count);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            heap_count = 0;
            outcome_q.delete();
            fail_total = 0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                outcome_q.push_back(apply_request(i_s_axis_tuser, t_value'(i_s_axis_tdata)));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.top    = i_m_axis_tdata[VALUE_W-1:0];
                got.total  = i_m_axis_tdata[VALUE_W +: TOTAL_W];
                got.status = i_m_axis_tuser;
                if (outcome_q.size() == 0) begin
                    $display("%0t: result with none expected: top %0d total %0d status %0d",
                             $time, $signed(got.top), got.total, got.status);
                    fail_total++;
                end else begin
                    want = outcome_q.pop_front();
                    if (want.top !== got.top) begin
                        $display("%0t: top_value expected %0d got %0d",
                                 $time, $signed(want.top), $signed(got.top));
                        fail_total++;
                    end
                    if (want.total !== got.total) begin
                        $display("%0t: entry_total expected %0d got %0d",
                                 $time, want.total, got.total);
                        fail_total++;
                    end
                    if (want.status !== got.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                        fail_total++;
                    end
                end
            end
        end
        o_pending    <= outcome_q.size();
        o_fail_count <= fail_total;
    end

endmodule

/* tb/tb.sv */
// top of the heap queue bench: clock, reset, request stimulus and the verdict
`timescale 1ns / 1ps

module tb
    import mhpq_pkg::*;
();

    localparam int CAPACITY    = 64;
    localparam int HOLD_CYCLES = 300;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [31:0] value
    logic                  s_axis_tuser;   // [0] operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [31:0] top_value, [38:32] entry_total
    logic [STATUS_W-1:0]   m_axis_tuser;   // [1:0] status

    int   fail_count;
    int   pending;
    int   gap_pct;
    int   stall_pct;
    logic hold_req;
    logic hold_done;

    max_heap_priority_queue_unit #(.CAPACITY(CAPACITY)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mhpq_result_checker #(.CAPACITY(CAPACITY)) result_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("max_heap_priority_queue_unit test failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off to back the block up
    initial begin
        m_axis_tready <= 1'b0;
        hold_done     <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_req(input logic op, input t_value val);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // mostly wide values, some narrow ones for ties, some at the edges
    function automatic t_value pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) begin
            return t_value'($urandom());
        end else if (sel < 85) begin
            return t_value'($signed($urandom_range(8)) - 4);
        end else begin
            case ($urandom_range(4))
                0:       return 32'sh7fff_ffff;
                1:       return 32'sh8000_0000;
                2:       return 32'sd0;
                3:       return -32'sd1;
                default: return 32'sd1;
            endcase
        end
    endfunction

    task automatic run_mix(input int insert_pct, input int count);
        logic op;
        repeat (count) begin
            op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
            send_req(op, pick_value());
        end
    endtask

    initial begin
        int gap_tab [4];
        int stall_tab [4];
        gap_tab   = '{0, 83, 0, 6};
        stall_tab = '{0, 0, 83, 6};
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_INSERT;
        hold_req      <= 1'b0;
        gap_pct   = 0;
        stall_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // removal from an empty heap, extremes, then drain including the last entry
        send_req(OP_REMOVE, 32'sh1234_5678);
        send_req(OP_INSERT, 32'sh7fff_ffff);
        send_req(OP_INSERT, 32'sh8000_0000);
        send_req(OP_INSERT, 32'sd0);
        send_req(OP_INSERT, -32'sd1);
        send_req(OP_INSERT, 32'sd1);
        repeat (5) send_req(OP_REMOVE, 32'shffff_ffff);
        send_req(OP_REMOVE, 32'sd0);
        // ties on sift up and sift down
        send_req(OP_INSERT, 32'sd5);
        send_req(OP_INSERT, 32'sd5);
        send_req(OP_INSERT, 32'sd5);
        send_req(OP_INSERT, 32'sd3);
        send_req(OP_INSERT, 32'sd5);
        repeat (5) send_req(OP_REMOVE, 32'sd7);

        for (int ph = 0; ph < 4; ph++) begin
            gap_pct   = gap_tab[ph];
            stall_pct = stall_tab[ph];
            // fill past capacity, drain past empty, then mixed traffic
            run_mix(90, 100);
            run_mix(10, 100);
            repeat (4) run_mix($urandom_range(30, 70), 45);
        end

        // result side holds off while requests keep coming
        gap_pct   = 0;
        stall_pct = 0;
        hold_req <= 1'b1;
        run_mix(60, 30);
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("max_heap_priority_queue_unit test passed");
        end else begin
            $display("max_heap_priority_queue_unit test failed");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/mhpq_pkg.sv
hdl/max_heap_priority_queue_unit.sv
tb/mhpq_result_checker.sv
tb/tb.sv
